@@ design/lidar_frame_presence_detector_defines.svh @@
// ----------------------------------------------------------------------------
// lidar frame presence detector assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LIDAR_FRAME_PRESENCE_DETECTOR_DEFINES_SVH
`define LIDAR_FRAME_PRESENCE_DETECTOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define LFPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfpd check failed");
// next-cycle implication
`define LFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfpd check failed");
`else
`define LFPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/lfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfpd_pkg
// shared types and constants of the lidar frame presence detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfpd_pkg;

  // frame format
  localparam logic [7:0]  HDR_BYTE      = 8'h59;
  localparam logic [15:0] NO_TARGET_MM  = 16'd9999;
  localparam logic [3:0]  POS_LAST      = 4'd8;

  // item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // presence codes
  localparam logic [1:0] PS_NONE     = 2'd0;
  localparam logic [1:0] PS_STAGED   = 2'd1;
  localparam logic [1:0] PS_LAUNCHED = 2'd2;

  // frame status codes
  localparam logic [1:0] FS_NONE     = 2'd0;
  localparam logic [1:0] FS_VALID    = 2'd1;
  localparam logic [1:0] FS_CSUM_ERR = 2'd2;

  // register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_AMP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_POLL_PER   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ARM_HOLD   = 3'd4;

  // register reset values
  localparam logic        RST_ENABLE    = 1'b1;
  localparam logic [15:0] RST_THRESHOLD = 16'd300;
  localparam logic [15:0] RST_MIN_AMP   = 16'd100;
  localparam logic [15:0] RST_POLL_PER  = 16'd100;
  localparam logic [15:0] RST_ARM_HOLD  = 16'd1000;

  // stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic        enable;
    logic [15:0] threshold_mm;
    logic [15:0] min_amplitude;
    logic [15:0] poll_period_ms;
    logic [15:0] arm_hold_ms;
  } cfg_t;

  // classified input transaction
  typedef struct packed {
    logic       is_tick;
    logic       is_hdr;
    logic [7:0] rx_byte;
  } item_t;

endpackage

@@ design/lfpd_front.sv @@
// ----------------------------------------------------------------------------
// lfpd_front
// input stage: takes transactions and tags them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfpd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tuser,
  input  logic [lfpd_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                item_valid,
  output lfpd_pkg::item_t                     item,
  input  logic                                item_ready
);

  logic            valid_r, valid_nxt;
  lfpd_pkg::item_t item_r, item_nxt;
  logic            take;

  assign in_tready = !valid_r || item_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt        = 1'b1;
      item_nxt.is_tick = (in_tuser == lfpd_pkg::MODE_TICK);
      item_nxt.is_hdr  = (in_tdata == lfpd_pkg::HDR_BYTE);
      item_nxt.rx_byte = in_tdata;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ design/lfpd_queue.sv @@
// ----------------------------------------------------------------------------
// lfpd_queue
// small fifo of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfpd_queue #(
  parameter int unsigned DEPTH = lfpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  lfpd_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lfpd_pkg::item_t pop_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lfpd_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/lfpd_back.sv @@
// ----------------------------------------------------------------------------
// lfpd_back
// frame parser, poll timer, presence machine and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lidar_frame_presence_detector_defines.svh"

module lfpd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lfpd_pkg::cfg_t                      cfg,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  lfpd_pkg::item_t                     item,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lfpd_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] cm_r, cm_nxt;
  logic [15:0] amp_r, amp_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic        fresh_r, fresh_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic [1:0]  pres_r, pres_nxt;
  logic [15:0] last_r, last_nxt;
  logic [15:0] staged_r, staged_nxt;
  logic        armed_r, armed_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [lfpd_pkg::OUT_DATA_W-1:0] odata_r, odata_nxt;

  logic        pop;
  logic [7:0]  b;
  logic [19:0] mm_full;
  logic [15:0] mm_sat;
  logic [15:0] mm_filt;
  logic [15:0] period;
  logic [17:0] thr3;
  logic [1:0]  status;
  logic        arm;
  logic        do_eval;

  assign pop        = item_valid && (!ovalid_r || out_tready);
  assign item_ready = !ovalid_r || out_tready;
  assign b          = item.rx_byte;

  // cm to mm: x10 as x8 + x2, saturate to 16 bits
  assign mm_full = {1'b0, cm_r, 3'b000} + {3'b000, cm_r, 1'b0};
  assign mm_sat  = (mm_full[19:16] != 4'd0) ? 16'hFFFF : mm_full[15:0];
  assign mm_filt = ((amp_r < cfg.min_amplitude) || (mm_sat == 16'd0))
                   ? lfpd_pkg::NO_TARGET_MM : mm_sat;

  assign period = (cfg.poll_period_ms == 16'd0) ? 16'd1 : cfg.poll_period_ms;
  assign thr3   = {1'b0, cfg.threshold_mm, 1'b0} + {2'b00, cfg.threshold_mm};

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    cm_nxt     = cm_r;
    amp_nxt    = amp_r;
    pend_nxt   = pend_r;
    fresh_nxt  = fresh_r;
    poll_nxt   = poll_r;
    pres_nxt   = pres_r;
    last_nxt   = last_r;
    staged_nxt = staged_r;
    armed_nxt  = armed_r;
    status     = lfpd_pkg::FS_NONE;
    arm        = 1'b0;
    do_eval    = 1'b0;

    if (pop && cfg.enable) begin
      if (!item.is_tick) begin
        // byte: frame assembly
        case (pos_r)
          4'd0: begin
            if (item.is_hdr) begin
              pos_nxt = 4'd1;
              sum_nxt = lfpd_pkg::HDR_BYTE;
            end
          end
          4'd1: begin
            if (item.is_hdr) begin
              pos_nxt = 4'd2;
              sum_nxt = sum_r + b;
            end else begin
              pos_nxt = 4'd0;
            end
          end
          lfpd_pkg::POS_LAST: begin
            if (b == sum_r) begin
              pend_nxt  = mm_filt;
              fresh_nxt = 1'b1;
              status    = lfpd_pkg::FS_VALID;
            end else begin
              status    = lfpd_pkg::FS_CSUM_ERR;
            end
            pos_nxt = 4'd0;
          end
          default: begin
            case (pos_r)
              4'd2:    cm_nxt  = {cm_r[15:8], b};
              4'd3:    cm_nxt  = {b, cm_r[7:0]};
              4'd4:    amp_nxt = {amp_r[15:8], b};
              4'd5:    amp_nxt = {b, amp_r[7:0]};
              default: ;
            endcase
            sum_nxt = sum_r + b;
            pos_nxt = (pos_r >= lfpd_pkg::POS_LAST) ? 4'd0 : pos_r + 4'd1;
          end
        endcase
      end else begin
        // tick: timers, poll and presence machine
        if ((pres_r == lfpd_pkg::PS_STAGED) && (staged_r != 16'hFFFF)) begin
          staged_nxt = staged_r + 16'd1;
        end
        poll_nxt = (poll_r != 16'hFFFF) ? poll_r + 16'd1 : poll_r;
        if (poll_nxt >= period) begin
          poll_nxt = 16'd0;
          if (fresh_r) begin
            fresh_nxt = 1'b0;
            do_eval   = 1'b1;
          end
        end
        if (do_eval) begin
          last_nxt = pend_r;
          case (pres_r)
            lfpd_pkg::PS_NONE: begin
              if (pend_r < cfg.threshold_mm) begin
                pres_nxt   = lfpd_pkg::PS_STAGED;
                staged_nxt = 16'd0;
                armed_nxt  = 1'b0;
              end
            end
            lfpd_pkg::PS_STAGED: begin
              if ({2'b00, pend_r} > thr3) begin
                pres_nxt = lfpd_pkg::PS_LAUNCHED;
              end else if (pend_r >= cfg.threshold_mm) begin
                pres_nxt = lfpd_pkg::PS_NONE;
              end
            end
            default: begin
              if (pend_r >= cfg.threshold_mm) begin
                pres_nxt = lfpd_pkg::PS_NONE;
              end
            end
          endcase
        end
        if ((pres_nxt == lfpd_pkg::PS_STAGED) && !armed_nxt &&
            (staged_nxt > cfg.arm_hold_ms)) begin
          armed_nxt = 1'b1;
          arm       = 1'b1;
        end
      end
    end
  end

  // result register
  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (pop) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {1'b0, status, arm, (pres_nxt != pres_r), last_nxt,
                    (pres_nxt == lfpd_pkg::PS_STAGED), pres_nxt};
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      cm_r     <= '0;
      amp_r    <= '0;
      pend_r   <= '0;
      fresh_r  <= 1'b0;
      poll_r   <= '0;
      pres_r   <= lfpd_pkg::PS_NONE;
      last_r   <= '0;
      staged_r <= '0;
      armed_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      cm_r     <= cm_nxt;
      amp_r    <= amp_nxt;
      pend_r   <= pend_nxt;
      fresh_r  <= fresh_nxt;
      poll_r   <= poll_nxt;
      pres_r   <= pres_nxt;
      last_r   <= last_nxt;
      staged_r <= staged_nxt;
      armed_r  <= armed_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // frame position never runs past the checksum byte
  `LFPD_ASSERT_IMPLY(a_pos_bound, clk, rst_n, 1'b1, pos_r <= lfpd_pkg::POS_LAST)
  // an arm pulse goes out only while staged and with the armed flag set
  `LFPD_ASSERT_IMPLY(a_arm_staged, clk, rst_n, ovalid_r && odata_r[20], (odata_r[1:0] == lfpd_pkg::PS_STAGED) && armed_r)
  // ticks never report a frame end
  `LFPD_ASSERT_NEXT(a_tick_no_frame, clk, rst_n, pop && item.is_tick, odata_r[22:21] == lfpd_pkg::FS_NONE)
  // every item taken from the queue shows up as a result
  `LFPD_ASSERT_NEXT(a_pop_result, clk, rst_n, pop, ovalid_r)

endmodule

@@ design/lidar_frame_presence_detector.sv @@
// ----------------------------------------------------------------------------
// lidar_frame_presence_detector
// time-of-flight lidar frame parser with poll-driven presence detection
// ----------------------------------------------------------------------------
// Each input transaction is either one received uart byte (in_tuser = 0) or one
// millisecond tick (in_tuser = 1), and each gives exactly one result
// transaction. Bytes build 9-byte frames (0x59 0x59, distance cm, amplitude,
// temperature, checksum); a good frame is stored as a pending distance in mm.
// Every poll period of ticks a fresh pending distance drives the no car /
// staged / launched machine, and a single auto-arm pulse follows staging that
// lasts longer than the hold time. The block takes one transaction per clock
// unless the result side stalls; a result passes the input register, queue and
// result register before it is offered. With the result side stalled it holds
// four transactions (input register, two queue entries, result register) before
// in_tready drops. All per-item work is done in the back end; the queue lets
// input and result sides stall apart. Registers are written through cfg_we /
// cfg_addr / cfg_wdata, by the user only while idle, not enforced by the block.
`timescale 1ns / 1ps

module lidar_frame_presence_detector #(
  parameter int unsigned QUEUE_DEPTH = lfpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic                                  in_tuser,   // [0] mode
  input  logic [lfpd_pkg::IN_DATA_W-1:0]        in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [1:0] presence_state, [2] car_present, [18:3] range_mm,
  // [19] state_changed, [20] auto_arm, [22:21] frame_status, [23] zero
  output logic [lfpd_pkg::OUT_DATA_W-1:0]       out_tdata,
  // register write port
  input  logic                                  cfg_we,
  input  logic [lfpd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  lfpd_pkg::cfg_t  cfg_r, cfg_nxt;
  lfpd_pkg::item_t front_item, queue_item;
  logic            front_valid, front_ready;
  logic            queue_valid, queue_ready;

  // register file, writes outside the map are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        lfpd_pkg::REG_ENABLE:    cfg_nxt.enable         = cfg_wdata[0];
        lfpd_pkg::REG_THRESHOLD: cfg_nxt.threshold_mm   = cfg_wdata;
        lfpd_pkg::REG_MIN_AMP:   cfg_nxt.min_amplitude  = cfg_wdata;
        lfpd_pkg::REG_POLL_PER:  cfg_nxt.poll_period_ms = cfg_wdata;
        lfpd_pkg::REG_ARM_HOLD:  cfg_nxt.arm_hold_ms    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= lfpd_pkg::RST_ENABLE;
      cfg_r.threshold_mm   <= lfpd_pkg::RST_THRESHOLD;
      cfg_r.min_amplitude  <= lfpd_pkg::RST_MIN_AMP;
      cfg_r.poll_period_ms <= lfpd_pkg::RST_POLL_PER;
      cfg_r.arm_hold_ms    <= lfpd_pkg::RST_ARM_HOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: registers and tags each transaction
  lfpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .item_valid (front_valid),
    .item       (front_item),
    .item_ready (front_ready)
  );

  // decoupling queue
  lfpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  // back end: parser, timers, presence machine, result register
  lfpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
